[rtl/csgl_pkg.sv]
// csgl_pkg: shared types and constants for the segmented character map lookup.
// Used by csgl_ctrl, csgl_dp and cmap_segment_glyph_lookup. No dependencies.
package csgl_pkg;

    // Default table depth in 16-bit words
    localparam int TABLE_WORDS_DEF = 4096;

    // Field widths
    localparam int SEG_W   = 10;  // seg_count
    localparam int WADDR_W = 12;  // word_address
    localparam int WORD_W  = 16;  // table word, glyph id
    localparam int CODE_W  = 16;  // char_code
    // Wide enough for any table index the scan can form (max below 2^17)
    localparam int IDX_W   = 18;

    // Stream payload widths
    localparam int S_TDATA_W = 48;  // 12 + 16 + 16 = 44, padded to bytes
    localparam int M_TDATA_W = 32;

    // Request opcodes (carried on s_axis_tuser)
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Which table word the datapath reads
    typedef enum logic [2:0] {
        RD_END   = 3'd0,
        RD_START = 3'd1,
        RD_DELTA = 3'd2,
        RD_ROFF  = 3'd3,
        RD_GLYPH = 3'd4
    } t_rd_sel;

    // How the result is formed
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_MAP   = 2'd1,
        RES_GLYPH = 2'd2,
        RES_OOR   = 2'd3
    } t_res_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic     mem_wr;    // store the write request's word
        logic     ld_code;   // capture lookup code
        logic     rd_en;     // issue a table read
        t_rd_sel  rd_sel;
        logic     cnt_inc;   // step to next segment
        logic     cnt_clr;   // rewind segment counter
        logic     ld_start;
        logic     ld_delta;
        logic     ld_gidx;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;  // move result into output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic seg_zero;     // no segments configured
        logic last_seg;     // current segment is the last one
        logic code_gt_rd;   // code > word just read
        logic code_lt_rd;   // code < word just read
        logic rd_zero;      // word just read is zero
        logic gidx_oob;     // glyph index lies beyond the table
        logic out_busy;     // output register full and not being taken
    } t_dp_sts;

endpackage

[rtl/csgl_ctrl.sv]
// csgl_ctrl: state machine sequencing table writes and segment scans.
// Depends on csgl_pkg; drives csgl_dp through t_dp_cmd / t_dp_sts.
module csgl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_op,
    output logic              o_req_ready,
    input  csgl_pkg::t_dp_sts i_sts,
    output csgl_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_END   = 8'b0000_0010,
        S_START = 8'b0000_0100,
        S_DELTA = 8'b0000_1000,
        S_ROFF  = 8'b0001_0000,
        S_GIDX  = 8'b0010_0000,
        S_GLYPH = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel  = csgl_pkg::RD_END;
        o_cmd.res_sel = csgl_pkg::RES_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_op == csgl_pkg::OP_WRITE) begin
                        o_cmd.mem_wr = 1'b1;
                    end else begin
                        o_cmd.ld_code = 1'b1;
                        if (i_sts.seg_zero) begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_DONE;
                        end else begin
                            // counter already at segment 0
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_END;
                        end
                    end
                end
            end
            S_END: begin
                if (i_sts.code_gt_rd) begin
                    if (i_sts.last_seg) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        o_cmd.rd_en   = 1'b1;
                        n_state       = S_END;
                    end
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = csgl_pkg::RD_START;
                    n_state      = S_START;
                end
            end
            S_START: begin
                if (i_sts.code_lt_rd) begin
                    if (i_sts.last_seg) begin
                        o_cmd.res_load = 1'b1;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.cnt_inc = 1'b1;
                        o_cmd.rd_en   = 1'b1;
                        n_state       = S_END;
                    end
                end else begin
                    o_cmd.ld_start = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    o_cmd.rd_sel   = csgl_pkg::RD_DELTA;
                    n_state        = S_DELTA;
                end
            end
            S_DELTA: begin
                o_cmd.ld_delta = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = csgl_pkg::RD_ROFF;
                n_state        = S_ROFF;
            end
            S_ROFF: begin
                if (i_sts.rd_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = csgl_pkg::RES_MAP;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.ld_gidx = 1'b1;
                    n_state       = S_GIDX;
                end
            end
            S_GIDX: begin
                if (i_sts.gidx_oob) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = csgl_pkg::RES_OOR;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = csgl_pkg::RD_GLYPH;
                    n_state      = S_GLYPH;
                end
            end
            S_GLYPH: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = csgl_pkg::RES_GLYPH;
                n_state        = S_DONE;
            end
            S_DONE: begin
                // wait for a free output register
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/csgl_dp.sv]
// csgl_dp: table memory, segment counter, address generation, result and
// output registers. Depends on csgl_pkg; commanded by csgl_ctrl.
module csgl_dp #(
    parameter int TABLE_WORDS = csgl_pkg::TABLE_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csgl_pkg::SEG_W-1:0]        i_cfg_wdata,
    input  logic [csgl_pkg::WADDR_W-1:0]      i_word_address,
    input  logic [csgl_pkg::WORD_W-1:0]       i_word_data,
    input  logic [csgl_pkg::CODE_W-1:0]       i_char_code,
    input  csgl_pkg::t_dp_cmd                 i_cmd,
    output csgl_pkg::t_dp_sts                 o_sts,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [csgl_pkg::WORD_W-1:0]       o_glyph_id,
    output logic [csgl_pkg::CODE_W-1:0]       o_char_echo,
    output logic                              o_out_of_range
);

    localparam int ADDR_W = $clog2(TABLE_WORDS);
    localparam int IDX_W  = csgl_pkg::IDX_W;
    localparam int SEG_W  = csgl_pkg::SEG_W;
    localparam int WORD_W = csgl_pkg::WORD_W;
    localparam int CODE_W = csgl_pkg::CODE_W;
    localparam logic [IDX_W-1:0] TBL_LIM = IDX_W'(TABLE_WORDS);

    logic [WORD_W-1:0] r_mem [TABLE_WORDS];

    logic [SEG_W-1:0]  r_seg_count;
    logic [SEG_W-1:0]  r_seg_idx;
    logic [CODE_W-1:0] r_code;
    logic [WORD_W-1:0] r_start;
    logic [WORD_W-1:0] r_delta;
    logic [IDX_W-1:0]  r_gidx;
    logic [WORD_W-1:0] r_rdq;
    logic              r_rd_oob;
    logic [WORD_W-1:0] r_glyph;
    logic              r_oor;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_glyph;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_oor;

    logic [SEG_W:0]    seg_nxt;
    logic [IDX_W-1:0]  seg_cur;
    logic [IDX_W-1:0]  s_ext;
    logic [IDX_W-1:0]  roff_at;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    logic [WORD_W-1:0] rdata;
    logic [IDX_W-1:0]  gidx;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count <= '0;
        end else if (i_cfg_we) begin
            r_seg_count <= i_cfg_wdata;
        end
    end

    // Segment counter
    assign seg_nxt = {1'b0, r_seg_idx} + (SEG_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_idx <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_seg_idx <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_seg_idx <= seg_nxt[SEG_W-1:0];
        end
    end

    // Table read address: end, start, delta, roff areas or the glyph array
    assign seg_cur = i_cmd.cnt_inc ? IDX_W'(seg_nxt) : IDX_W'(r_seg_idx);
    assign s_ext   = IDX_W'(r_seg_count);
    assign roff_at = s_ext + s_ext + s_ext + IDX_W'(1) + IDX_W'(r_seg_idx);

    always_comb begin
        case (i_cmd.rd_sel)
            csgl_pkg::RD_END:   rd_idx = seg_cur;
            csgl_pkg::RD_START: rd_idx = s_ext + IDX_W'(1) + seg_cur;
            csgl_pkg::RD_DELTA: rd_idx = s_ext + s_ext + IDX_W'(1) + seg_cur;
            csgl_pkg::RD_ROFF:  rd_idx = roff_at;
            csgl_pkg::RD_GLYPH: rd_idx = r_gidx;
            default:            rd_idx = seg_cur;
        endcase
    end

    assign wr_idx = IDX_W'(i_word_address);

    // Table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && (wr_idx < TBL_LIM)) begin
            r_mem[wr_idx[ADDR_W-1:0]] <= i_word_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_oob <= !(rd_idx < TBL_LIM);
            if (rd_idx < TBL_LIM) begin
                r_rdq <= r_mem[rd_idx[ADDR_W-1:0]];
            end
        end
    end

    // words beyond the table read as zero
    assign rdata = r_rd_oob ? '0 : r_rdq;

    // Glyph array index
    assign gidx = roff_at + IDX_W'(rdata[WORD_W-1:1]) + IDX_W'(r_code - r_start);

    // Lookup operand registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_code) begin
            r_code <= i_char_code;
        end
        if (i_cmd.ld_start) begin
            r_start <= rdata;
        end
        if (i_cmd.ld_delta) begin
            r_delta <= rdata;
        end
        if (i_cmd.ld_gidx) begin
            r_gidx <= gidx;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                csgl_pkg::RES_ZERO: begin
                    r_glyph <= '0;
                    r_oor   <= 1'b0;
                end
                csgl_pkg::RES_MAP: begin
                    r_glyph <= r_code + r_delta;
                    r_oor   <= 1'b0;
                end
                csgl_pkg::RES_GLYPH: begin
                    r_glyph <= (rdata == '0) ? '0 : rdata + r_delta;
                    r_oor   <= 1'b0;
                end
                csgl_pkg::RES_OOR: begin
                    r_glyph <= '0;
                    r_oor   <= 1'b1;
                end
                default: begin
                    r_glyph <= '0;
                    r_oor   <= 1'b0;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_glyph <= r_glyph;
            r_out_code  <= r_code;
            r_out_oor   <= r_oor;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_glyph_id     = r_out_glyph;
    assign o_char_echo    = r_out_code;
    assign o_out_of_range = r_out_oor;

    // Status to controller
    always_comb begin
        o_sts            = '0;
        o_sts.seg_zero   = (r_seg_count == '0);
        o_sts.last_seg   = (seg_nxt == {1'b0, r_seg_count});
        o_sts.code_gt_rd = (r_code > rdata);
        o_sts.code_lt_rd = (r_code < rdata);
        o_sts.rd_zero    = (rdata == '0);
        o_sts.gidx_oob   = !(r_gidx < TBL_LIM);
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

endmodule

[rtl/cmap_segment_glyph_lookup.sv]
// cmap_segment_glyph_lookup: top level of the segmented character map lookup.
// Depends on csgl_pkg, csgl_ctrl and csgl_dp.
//
// Usage:
//   Requests arrive on the s_axis channel. tuser selects the kind: a write
//   request stores word_data at word_address in the table; a lookup request
//   maps char_code to a glyph id. Writes give no result; each lookup gives
//   one result on m_axis (glyph id, echoed code, out-of-range flag).
//   seg_count is loaded via i_cfg_we / i_cfg_wdata; the user must do so only while the block idles, unenforced.
// Scan: a write request is stored as it is accepted. A lookup steps past
//   each segment rejected by its end word or by its start word, then reads
//   delta, range offset and possibly glyph words of the matching segment.
//   Its result becomes valid in the same cycle the block is next ready,
//   which is also the first cycle the next request is taken.
// Reset: synchronous, active low; seg_count returns to 0, the controller
//   goes idle and the output register empties. Table contents are kept and
//   are undefined until written.
// Stall: a result waits in the output register while m_axis_tready is low;
//   new requests are still taken and the next lookup runs up to its result,
//   then holds until the output register frees.
module cmap_segment_glyph_lookup #(
    parameter int TABLE_WORDS = csgl_pkg::TABLE_WORDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: seg_count
    input  logic                               i_cfg_we,
    input  logic [csgl_pkg::SEG_W-1:0]         i_cfg_wdata,
    // request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [11:0] word_address, [27:12] word_data, [43:28] char_code, [47:44] zero
    input  logic [csgl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] opcode
    input  logic                               s_axis_tuser,
    // result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] glyph_id, [31:16] char_echo
    output logic [csgl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] out_of_range
    output logic                               m_axis_tuser
);

    csgl_pkg::t_dp_cmd cmd;
    csgl_pkg::t_dp_sts sts;

    logic [csgl_pkg::WORD_W-1:0] glyph_id;
    logic [csgl_pkg::CODE_W-1:0] char_echo;

    // Sequencer
    csgl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_op    (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Table, scan datapath and output register
    csgl_dp #(
        .TABLE_WORDS (TABLE_WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_word_address (s_axis_tdata[11:0]),
        .i_word_data    (s_axis_tdata[27:12]),
        .i_char_code    (s_axis_tdata[43:28]),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_glyph_id     (glyph_id),
        .o_char_echo    (char_echo),
        .o_out_of_range (m_axis_tuser)
    );

    assign m_axis_tdata = {char_echo, glyph_id};

endmodule
